>>> rtl/ncg_pkg.sv
// shared types and palette constants for the nearest color group block
`timescale 1ns / 1ps

package ncg_pkg;

   // fixed point widths
   localparam int HUE_W  = 25;            // degrees in Q16, below 360<<16
   localparam int FOLD_W = 24;            // folded hue distance, at most 180<<16
   localparam int SAT_W  = 17;            // saturation Q16, at most 1.0
   localparam int VAL_W  = 8;
   localparam int DH_W   = 17;
   localparam int DV_W   = 9;
   localparam int DIST_W = 35;
   localparam int QUO_W  = 22;            // quotient bits out of the divider
   localparam int DIV_STAGES = QUO_W;
   localparam int SAT_SHIFT  = 5;         // saturation numerator is pre-scaled by 32

   localparam logic [HUE_W-1:0] HUE_FULL   = 25'd23592960;   // 360 << 16
   localparam logic [HUE_W-1:0] HUE_HALF   = 25'd11796480;   // 180 << 16
   localparam logic [HUE_W-1:0] HUE_BASE_G = 25'd7864320;    // 120 << 16
   localparam logic [HUE_W-1:0] HUE_BASE_B = 25'd15728640;   // 240 << 16

   // reciprocal of 180 scaled by 2^32, rounded up
   localparam logic [24:0] RECIP_180   = 25'd23860930;
   localparam int          RECIP_SHIFT = 32;

   localparam logic [13:0] SIXTY = 14'd60;

   // palette in hsv, precomputed from the rgb table
   localparam int TABLE_LEN = 21;

   localparam logic [HUE_W-1:0] PAL_HUE [TABLE_LEN] = '{
      25'd0,        25'd0,
      25'd0,        25'd19660800, 25'd15728640,
      25'd11796480, 25'd7864320,  25'd3932160,
      25'd0,        25'd19660800, 25'd15728640,
      25'd11796480, 25'd7864320,  25'd3932160,
      25'd0,        25'd19660800, 25'd15728640,
      25'd11796480, 25'd7864320,  25'd3932160,
      25'd0
   };

   localparam logic [SAT_W-1:0] PAL_SAT [TABLE_LEN] = '{
      17'd0,     17'd0,
      17'd65536, 17'd65536, 17'd65536,
      17'd65536, 17'd65536, 17'd65536,
      17'd32639, 17'd32639, 17'd32639,
      17'd32639, 17'd32639, 17'd32639,
      17'd65536, 17'd65536, 17'd65536,
      17'd65536, 17'd65536, 17'd65536,
      17'd0
   };

   localparam logic [VAL_W-1:0] PAL_VAL [TABLE_LEN] = '{
      8'd255, 8'd128,
      8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255,
      8'd128, 8'd128, 8'd128,
      8'd128, 8'd128, 8'd128,
      8'd0
   };

   // which channel holds the maximum
   typedef enum logic [1:0] {
      SEC_RED,
      SEC_GREEN,
      SEC_BLUE
   } sector_type;

   // pixel in hsv, handed from cell to cell
   typedef struct packed {
      logic             vld;
      logic [HUE_W-1:0] hue;
      logic [SAT_W-1:0] sat;
      logic [VAL_W-1:0] val;
   } hsv_word_type;

   // running best distance
   typedef struct packed {
      logic              vld;
      logic [DIST_W-1:0] cost;
   } best_word_type;

endpackage

>>> rtl/nearest_color_group.sv
// Nearest palette color: each accepted rgb word gives the index of the closest of the
// palette colors under an hsv distance. A new word is taken in every clock; busy stays
// low. Each result appears on rsp_group for one cycle with rsp_strobe. A word is
// registered at the hsv input and divider entry, in each stage of the 22-stage
// bit-per-stage hue and saturation dividers and at the hsv output, then in the pixel
// register of each palette cell ahead of the last and in the distance registers of
// the last cell. The receiver cannot stall the output. Ties go to the lowest index.
`timescale 1ns / 1ps

module nearest_color_group
   import ncg_pkg::*;
#(
   parameter int PALETTE_SIZE = 21
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_strobe,
   output logic [4:0] rsp_group
);

   localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
   localparam int LAT   = PALETTE_SIZE + 28;

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // hsv front end
   hsv_word_type pix [PALETTE_SIZE+1];

   ncg_hsv u_hsv (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (accept),
      .in_red   (req_red),
      .in_green (req_green),
      .in_blue  (req_blue),
      .out_word (pix[0])
   );

   // chain of palette cells
   best_word_type    best [PALETTE_SIZE+1];
   logic [IDX_W-1:0] idx  [PALETTE_SIZE+1];

   assign best[0] = '0;
   assign idx[0]  = '0;

   for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
      ncg_cell #(
         .INDEX (i),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .pix_in   (pix[i]),
         .pix_out  (pix[i+1]),
         .best_in  (best[i]),
         .idx_in   (idx[i]),
         .best_out (best[i+1]),
         .idx_out  (idx[i+1])
      );
   end

   assign rsp_strobe = best[PALETTE_SIZE].vld;
   assign rsp_group  = 5'(idx[PALETTE_SIZE]);

   // checks
   a_group_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_group < 5'(TABLE_LEN)))
      else $error("group index past the palette table");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LAT))
      else $error("result without a matching accepted word");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

endmodule

>>> rtl/ncg_hsv.sv
// rgb to hsv converter with pipelined restoring dividers for hue and saturation
`timescale 1ns / 1ps

module ncg_hsv
   import ncg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_vld,
   input  logic [7:0]   in_red,
   input  logic [7:0]   in_green,
   input  logic [7:0]   in_blue,
   output hsv_word_type out_word
);

   // input word register
   logic       vld_ff;
   logic [7:0] red_ff, green_ff, blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
      red_ff   <= in_red;
      green_ff <= in_green;
      blue_ff  <= in_blue;
   end

   // max, min and sector
   logic [7:0]  cmax, cmin, diff, anum;
   logic        neg;
   sector_type  sec;
   logic [13:0] a60;

   always_comb begin
      cmax = red_ff;
      if (green_ff > cmax) cmax = green_ff;
      if (blue_ff > cmax) cmax = blue_ff;
      cmin = red_ff;
      if (green_ff < cmin) cmin = green_ff;
      if (blue_ff < cmin) cmin = blue_ff;
      diff = cmax - cmin;
      if (cmax == red_ff) begin
         sec  = SEC_RED;
         neg  = green_ff < blue_ff;
         anum = neg ? (blue_ff - green_ff) : (green_ff - blue_ff);
      end else if (cmax == green_ff) begin
         sec  = SEC_GREEN;
         neg  = blue_ff < red_ff;
         anum = neg ? (red_ff - blue_ff) : (blue_ff - red_ff);
      end else begin
         sec  = SEC_BLUE;
         neg  = red_ff < green_ff;
         anum = neg ? (green_ff - red_ff) : (red_ff - green_ff);
      end
      a60 = {6'd0, anum} * SIXTY;
   end

   // divider pipeline, index 0 is the entry
   logic [7:0]       rt_ff [DIV_STAGES+1];
   logic [QUO_W-1:0] lt_ff [DIV_STAGES+1];
   logic [QUO_W-1:0] qt_ff [DIV_STAGES+1];
   logic [7:0]       rs_ff [DIV_STAGES+1];
   logic [QUO_W-1:0] ls_ff [DIV_STAGES+1];
   logic [QUO_W-1:0] qs_ff [DIV_STAGES+1];
   logic [7:0]       dt_ff [DIV_STAGES+1];
   logic [7:0]       ds_ff [DIV_STAGES+1];
   sector_type       sec_ff [DIV_STAGES+1];
   logic             neg_ff [DIV_STAGES+1];
   logic             zero_ff [DIV_STAGES+1];
   logic             dv_ff [DIV_STAGES+1];

   // entry: hue numerator is a60<<16, saturation numerator is diff<<21
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= vld_ff;
      end
      rt_ff[0]   <= {2'd0, a60[13:8]} << 2 | {6'd0, a60[7:6]};
      lt_ff[0]   <= {a60[5:0], 16'd0};
      qt_ff[0]   <= '0;
      rs_ff[0]   <= {1'b0, diff[7:1]};
      ls_ff[0]   <= {diff[0], 21'd0};
      qs_ff[0]   <= '0;
      dt_ff[0]   <= diff;
      ds_ff[0]   <= cmax;
      sec_ff[0]  <= sec;
      neg_ff[0]  <= neg;
      zero_ff[0] <= (diff == 8'd0);
   end

   // one quotient bit per stage for each divider
   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      logic [8:0] r2t, r2s;
      logic       get, ges;

      always_comb begin
         r2t = {rt_ff[k-1], lt_ff[k-1][QUO_W-1]};
         r2s = {rs_ff[k-1], ls_ff[k-1][QUO_W-1]};
         get = r2t >= {1'b0, dt_ff[k-1]};
         ges = r2s >= {1'b0, ds_ff[k-1]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else begin
            dv_ff[k] <= dv_ff[k-1];
         end
         rt_ff[k]   <= get ? 8'(r2t - {1'b0, dt_ff[k-1]}) : r2t[7:0];
         rs_ff[k]   <= ges ? 8'(r2s - {1'b0, ds_ff[k-1]}) : r2s[7:0];
         lt_ff[k]   <= {lt_ff[k-1][QUO_W-2:0], 1'b0};
         ls_ff[k]   <= {ls_ff[k-1][QUO_W-2:0], 1'b0};
         qt_ff[k]   <= {qt_ff[k-1][QUO_W-2:0], get};
         qs_ff[k]   <= {qs_ff[k-1][QUO_W-2:0], ges};
         dt_ff[k]   <= dt_ff[k-1];
         ds_ff[k]   <= ds_ff[k-1];
         sec_ff[k]  <= sec_ff[k-1];
         neg_ff[k]  <= neg_ff[k-1];
         zero_ff[k] <= zero_ff[k-1];
      end
   end

   // hue assembly from sector base and offset
   logic [HUE_W-1:0] t_ext, base, hue_in;
   logic [SAT_W-1:0] sat_in;

   always_comb begin
      t_ext = {{(HUE_W-QUO_W){1'b0}}, qt_ff[DIV_STAGES]};
      case (sec_ff[DIV_STAGES])
         SEC_RED:   base = neg_ff[DIV_STAGES] ? HUE_FULL : '0;
         SEC_GREEN: base = HUE_BASE_G;
         SEC_BLUE:  base = HUE_BASE_B;
         default:   base = '0;
      endcase
      if (zero_ff[DIV_STAGES]) begin
         hue_in = '0;
         sat_in = '0;
      end else begin
         hue_in = neg_ff[DIV_STAGES] ? (base - t_ext) : (base + t_ext);
         sat_in = qs_ff[DIV_STAGES][SAT_SHIFT +: SAT_W];
      end
   end

   // output word register
   hsv_word_type word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.vld <= 1'b0;
      end else begin
         word_ff.vld <= dv_ff[DIV_STAGES];
      end
      word_ff.hue <= hue_in;
      word_ff.sat <= sat_in;
      word_ff.val <= ds_ff[DIV_STAGES];
   end

   assign out_word = word_ff;

endmodule

>>> rtl/ncg_cell.sv
// one palette entry: distance to the passing pixel and running minimum
`timescale 1ns / 1ps

module ncg_cell
   import ncg_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int IDX_W = 5
)
(
   input  logic          clock,
   input  logic          reset,
   input  hsv_word_type  pix_in,
   output hsv_word_type  pix_out,
   input  best_word_type best_in,
   input  logic [IDX_W-1:0] idx_in,
   output best_word_type best_out,
   output logic [IDX_W-1:0] idx_out
);

   localparam int ENTRY = (INDEX < TABLE_LEN) ? INDEX : TABLE_LEN - 1;
   localparam logic [HUE_W-1:0] HC = PAL_HUE[ENTRY];
   localparam logic [SAT_W-1:0] SC = PAL_SAT[ENTRY];
   localparam logic [VAL_W-1:0] VC = PAL_VAL[ENTRY];
   localparam logic FIRST = (INDEX == 0);

   // pixel passes to the neighbor
   hsv_word_type pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff.vld <= 1'b0;
      end else begin
         pix_ff.vld <= pix_in.vld;
      end
      pix_ff.hue <= pix_in.hue;
      pix_ff.sat <= pix_in.sat;
      pix_ff.val <= pix_in.val;
   end

   assign pix_out = pix_ff;

   // absolute differences, hue folded around the circle
   logic [HUE_W-1:0]  dhue;
   logic [FOLD_W-1:0] fold_in;
   logic [SAT_W-1:0]  ds_in;
   logic [VAL_W-1:0]  xv;
   logic [DV_W-1:0]   dv_in;

   always_comb begin
      dhue    = (HC >= pix_in.hue) ? (HC - pix_in.hue) : (pix_in.hue - HC);
      fold_in = (dhue > HUE_HALF) ? FOLD_W'(HUE_FULL - dhue) : dhue[FOLD_W-1:0];
      ds_in   = (SC >= pix_in.sat) ? (SC - pix_in.sat) : (pix_in.sat - SC);
      xv      = (VC >= pix_in.val) ? (VC - pix_in.val) : (pix_in.val - VC);
      // x * 65536 / 65025 for x up to 255
      dv_in   = {1'b0, xv} + {8'd0, xv[7]} + {8'd0, (xv == 8'hFF)};
   end

   logic              v1_ff, v2_ff, v3_ff;
   logic [FOLD_W-1:0] fold_ff;
   logic [SAT_W-1:0]  ds1_ff, ds2_ff;
   logic [DV_W-1:0]   dv1_ff, dv2_ff;
   logic [DH_W-1:0]   dh_ff;
   logic [2*DH_W-1:0] sqh_ff, sqs_ff;
   logic [2*DV_W-1:0] sqv_ff;

   // hue difference over 180 by reciprocal
   logic [FOLD_W+24:0] prod;
   assign prod = {25'd0, fold_ff} * {{FOLD_W{1'b0}}, RECIP_180};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= pix_in.vld;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      fold_ff <= fold_in;
      ds1_ff  <= ds_in;
      dv1_ff  <= dv_in;
      dh_ff   <= prod[RECIP_SHIFT +: DH_W];
      ds2_ff  <= ds1_ff;
      dv2_ff  <= dv1_ff;
      sqh_ff  <= {{DH_W{1'b0}}, dh_ff} * {{DH_W{1'b0}}, dh_ff};
      sqs_ff  <= {{SAT_W{1'b0}}, ds2_ff} * {{SAT_W{1'b0}}, ds2_ff};
      sqv_ff  <= {{DV_W{1'b0}}, dv2_ff} * {{DV_W{1'b0}}, dv2_ff};
   end

   // sum and compare against the incoming best
   logic [DIST_W-1:0] sum;
   logic              take;

   always_comb begin
      sum  = DIST_W'(sqh_ff) + DIST_W'(sqs_ff) + DIST_W'(sqv_ff);
      take = FIRST || (sum < best_in.cost);
   end

   best_word_type    best_ff;
   logic [IDX_W-1:0] idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff.vld <= 1'b0;
      end else begin
         best_ff.vld <= v3_ff;
      end
      best_ff.cost <= take ? sum : best_in.cost;
      idx_ff       <= take ? IDX_W'(INDEX) : idx_in;
   end

   assign best_out = best_ff;
   assign idx_out  = idx_ff;

endmodule
